[rtl/set_assoc_cache_mru_writeback_defines.svh]
`ifndef SET_ASSOC_CACHE_MRU_WRITEBACK_DEFINES_SVH
`define SET_ASSOC_CACHE_MRU_WRITEBACK_DEFINES_SVH

// Checked only out of reset.
`define SACM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define SACM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/sacm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sacm_pkg;

   localparam int WAYS_DEF        = 4;
   localparam int BLOCK_BYTES_DEF = 32;
   localparam int CACHE_BYTES_DEF = 8192;

   localparam int ADDR_W = 32;
   localparam int KIND_W = 2;
   localparam int RSP_W  = 8;

   typedef enum logic [KIND_W-1:0] {
      ACC_READ  = 2'd0,
      ACC_WRITE = 2'd1,
      ACC_FETCH = 2'd2
   } access_kind_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } ctl_state_type;

endpackage

`default_nettype wire

[rtl/set_assoc_cache_mru_writeback.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload
// req_      in   tuser[1:0] access_kind, tdata[31:0] byte_address
// rsp_      out  tdata[0] hit, [1] dirty_eviction, [3:2] way_used, [7:4] zero
//
// One access per cycle while the output is not stalled. The transaction edge reads
// the set row from the tag memory; the compare stage then does the compare and
// write-back and loads the output register, which drives rsp_tvalid.
// Back-to-back accesses to one set are forwarded.
// After reset a clearing pass writes every set row (SETS of them, 64 by
// default), with req_tready low. A stalled output holds the compare stage;
// req_tready drops once that stage is full and blocked.
// Geometry parameters are powers of two.

module set_assoc_cache_mru_writeback #(
   parameter int WAYS        = sacm_pkg::WAYS_DEF,
   parameter int BLOCK_BYTES = sacm_pkg::BLOCK_BYTES_DEF,
   parameter int CACHE_BYTES = sacm_pkg::CACHE_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [sacm_pkg::ADDR_W-1:0] req_tdata,  // [31:0] byte_address
   input  wire logic [sacm_pkg::KIND_W-1:0] req_tuser,  // [1:0] access_kind
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [sacm_pkg::RSP_W-1:0]       rsp_tdata   // [0] hit, [1] dirty_eviction,
                                                        // [3:2] way_used, [7:4] zero
);
   import sacm_pkg::*;

   localparam int RAW_SETS = CACHE_BYTES / BLOCK_BYTES / WAYS;
   localparam int SETS     = (RAW_SETS > 0) ? RAW_SETS : 1;
   localparam int OFF_W    = $clog2(BLOCK_BYTES);
   localparam int SET_LOG  = $clog2(SETS);
   localparam int SET_W    = (SET_LOG > 0) ? SET_LOG : 1;
   localparam int TAG_W    = ADDR_W - OFF_W - SET_LOG;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W    = WAY_W + WAYS * (TAG_W + 2);

   // tag memory, one row per set: {mru, tags, dirty bits, valid bits}
   logic [ROW_W-1:0] tag_mem [SETS];

   ctl_state_type state_ff, state_in;
   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             clr_last;
   logic             clr_we;
   logic             run_en;

   logic             req_acc;
   logic [SET_W-1:0] req_set;
   logic [ROW_W-1:0] rd_row_ff;

   logic              s1_vld_ff, s1_vld_in;
   logic [KIND_W-1:0] s1_kind_ff;
   logic [SET_W-1:0]  s1_set_ff;
   logic [TAG_W-1:0]  s1_tag_ff;
   logic              s1_adv;

   logic             fwd_vld_ff, fwd_vld_in;
   logic [SET_W-1:0] fwd_set_ff;
   logic [ROW_W-1:0] fwd_row_ff;

   logic [ROW_W-1:0]             cur_row;
   logic [WAYS-1:0]              cur_valid, cur_dirty;
   logic [WAYS-1:0][TAG_W-1:0]   cur_tag;
   logic [WAY_W-1:0]             cur_mru;
   logic [WAYS-1:0]              new_valid, new_dirty;
   logic [WAYS-1:0][TAG_W-1:0]   new_tag;
   logic [ROW_W-1:0]             new_row;

   logic             is_write;
   logic             hit;
   logic [WAY_W-1:0] hit_way;
   logic             any_free;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] use_way;
   logic             evict;
   logic [WAY_W+1:0] way_ext;

   logic                   mem_we;
   logic [SET_W-1:0]       mem_wa;
   logic [ROW_W-1:0]       mem_wd;

   logic             rsp_vld_ff, rsp_vld_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // ---------------- control: clearing pass, then service ----------------
   assign clr_last = (clr_cnt_ff == SET_W'(SETS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_RUN;
         ST_RUN:   state_in = ST_RUN;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      clr_we = 1'b0;
      run_en = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clr_we = 1'b1;
         ST_RUN:   run_en = 1'b1;
         default:  clr_we = 1'b0;
      endcase
   end

   assign clr_cnt_in = clr_we ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ---------------- request side and set row read ----------------
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = run_en && (!s1_vld_ff || s1_adv);
   assign req_acc    = req_tvalid && req_tready;
   assign req_set    = (SETS > 1) ? SET_W'(req_tdata >> OFF_W) : '0;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_row_ff  <= tag_mem[req_set];
         s1_kind_ff <= req_tuser;
         s1_set_ff  <= req_set;
         s1_tag_ff  <= TAG_W'(req_tdata >> (OFF_W + SET_LOG));
      end
   end

   assign s1_vld_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);

   // ---------------- compare and update ----------------
   // the previous update may have landed on the same edge as this read
   assign cur_row = (fwd_vld_ff && fwd_set_ff == s1_set_ff) ? fwd_row_ff : rd_row_ff;
   assign {cur_mru, cur_tag, cur_dirty, cur_valid} = cur_row;
   assign is_write = (s1_kind_ff == ACC_WRITE);

   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      any_free = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (cur_valid[w] && cur_tag[w] == s1_tag_ff) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!cur_valid[w]) begin
            any_free = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      use_way   = hit ? hit_way : (any_free ? free_way : cur_mru);
      evict     = !hit && cur_valid[use_way] && cur_dirty[use_way];
      new_valid = cur_valid;
      new_dirty = cur_dirty;
      new_tag   = cur_tag;
      new_valid[use_way] = 1'b1;
      if (hit) begin
         new_dirty[use_way] = cur_dirty[use_way] | is_write;
      end else begin
         new_dirty[use_way] = is_write;
         new_tag[use_way]   = s1_tag_ff;
      end
      new_row = {use_way, new_tag, new_dirty, new_valid};
   end

   assign fwd_vld_in = s1_adv ? 1'b1 : fwd_vld_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         fwd_set_ff <= s1_set_ff;
         fwd_row_ff <= new_row;
      end
   end

   // ---------------- tag memory ----------------
   assign mem_we = clr_we || s1_adv;
   assign mem_wa = clr_we ? clr_cnt_ff : s1_set_ff;
   assign mem_wd = clr_we ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_wa] <= mem_wd;
      end
   end

   // ---------------- output register ----------------
   assign way_ext     = {2'b00, use_way};
   assign rsp_data_in = {4'b0000, way_ext[1:0], evict, hit};
   assign rsp_vld_in  = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/sacm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_cache_mru_writeback_defines.svh"

module sacm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic [sacm_pkg::ADDR_W-1:0] req_tdata,
   input wire logic [sacm_pkg::KIND_W-1:0] req_tuser,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [sacm_pkg::RSP_W-1:0]  rsp_tdata
);
   import sacm_pkg::*;

   logic       req_acc, rsp_acc;
   logic [2:0] pend_ff, pend_in;
   logic       req_seen;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_acc  = rsp_tvalid && rsp_tready;
   assign req_seen = (req_tuser == ACC_WRITE) || (req_tdata != '0) || 1'b1;
   assign pend_in  = pend_ff + {2'b00, req_acc && req_seen} - {2'b00, rsp_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // the clearing pass keeps the request side closed right after reset
   `SACM_ASSERT_ALWAYS(a_clear_after_reset, reset |=> !req_tready, "request taken during clear")

   `SACM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
                "stalled result changed")

   `SACM_ASSERT(a_hit_no_evict, rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]),
                "hit reported with a dirty eviction")

   // compare stage plus output register: never more than two in flight
   `SACM_ASSERT(a_pending, (pend_ff <= 3'd2) && (!rsp_tvalid || pend_ff != 3'd0),
                "result without a matching request")

endmodule

bind set_assoc_cache_mru_writeback sacm_checker u_sacm_checker (.*);

`default_nettype wire
